// File: rtl/jscs_pkg.sv
`timescale 1ns / 1ps

package jscs_pkg;

   // Scanner modes.
   localparam logic [2:0] MODE_COMMENT  = 3'd0;
   localparam logic [2:0] MODE_LINECMT  = 3'd1;
   localparam logic [2:0] MODE_QUOTES   = 3'd2;
   localparam logic [2:0] MODE_SLASH    = 3'd3;
   localparam logic [2:0] MODE_BEGSLASH = 3'd4;
   localparam logic [2:0] MODE_TEXT     = 3'd5;
   localparam logic [2:0] MODE_NEWLINE  = 3'd6;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam int unsigned MAX_BYTES = 3;

   // Bytes produced by one input item, first byte in slot 0.
   typedef struct packed {
      logic [1:0]                     count;
      logic [MAX_BYTES-1:0][7:0]      bytes;
   } emit_type;

   // Output queue status seen by the top level.
   typedef struct packed {
      logic [1:0] count;
      logic       free;
   } outq_status_type;

endpackage

// File: rtl/js_comment_strip_filter.sv
`timescale 1ns / 1ps
// The first byte of an item's result appears as a response beat in the cycle after the
// request beat is accepted. One item per cycle while each item yields at most one byte
// and the response side does not stall; an item that yields more bytes holds the single
// output register until its last byte is taken, and stalls the request side meanwhile.
// Reset: mode returns to text, the previous byte to zero, and the output register empties.

module js_comment_strip_filter
   import jscs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   emit_type        emit;
   outq_status_type status;
   logic [2:0]      mode;
   logic            req_take;
   logic            rsp_take;

   assign req_stall = !status.free;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   jscs_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_take),
      .char_code    (req_char_code),
      .end_of_input (req_end_of_input),
      .emit         (emit),
      .mode         (mode)
   );

   jscs_outq u_outq (
      .clock           (clock),
      .reset           (reset),
      .load            (req_take),
      .emit            (emit),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .status          (status)
   );

   // An end-of-input beat always leaves the scanner in text mode.
   a_end_resets_mode: assert property (@(posedge clock) disable iff (reset)
      req_take && req_end_of_input |=> mode == MODE_TEXT)
      else $error("scanner not back in text mode after end of input");

   // The request side is held off only while undelivered bytes remain.
   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && status.count != 2'd0)
      else $error("request stalled with empty output register");

   // Without a new item, each delivered beat removes exactly one byte.
   a_one_byte_per_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !req_take |=> status.count == $past(status.count) - 2'd1)
      else $error("output byte count did not drop by one");

endmodule

// File: rtl/jscs_scan.sv
`timescale 1ns / 1ps

module jscs_scan
   import jscs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_code,
   input  logic       end_of_input,
   output emit_type   emit,
   output logic [2:0] mode
);

   logic [2:0] mode_ff, mode_in;
   logic [7:0] prev_ff, prev_in;

   always_comb begin
      mode_in    = mode_ff;
      prev_in    = prev_ff;
      emit.count = 2'd0;
      emit.bytes = '0;
      case (mode_ff)
         MODE_COMMENT: begin
            if (!end_of_input) begin
               if (char_code == CH_SLASH) begin
                  if (prev_ff == CH_STAR) begin
                     mode_in = MODE_TEXT;
                  end
                  prev_in = 8'h00;
               end else begin
                  prev_in = char_code;
               end
            end
         end
         MODE_LINECMT: begin
            if (!end_of_input && char_code == CH_LF) begin
               mode_in = MODE_NEWLINE;
            end
         end
         MODE_QUOTES: begin
            if (!end_of_input) begin
               // An escaped quote does not close the string.
               if (char_code == CH_QUOTE && prev_ff != CH_BSLASH) begin
                  mode_in = MODE_TEXT;
               end
               prev_in       = char_code;
               emit.count    = 2'd1;
               emit.bytes[0] = char_code;
            end
         end
         MODE_SLASH, MODE_BEGSLASH: begin
            if (end_of_input) begin
               if (mode_ff == MODE_BEGSLASH) begin
                  emit.count = 2'd3;
                  emit.bytes = {CH_LF, CH_SLASH, CH_LF};
               end else begin
                  emit.count = 2'd2;
                  emit.bytes = {8'h00, CH_LF, CH_SLASH};
               end
            end else if (char_code == CH_SLASH) begin
               mode_in = MODE_LINECMT;
            end else if (char_code == CH_STAR) begin
               prev_in = 8'h00;
               mode_in = MODE_COMMENT;
            end else if (char_code == CH_LF) begin
               mode_in = MODE_NEWLINE;
               if (mode_ff == MODE_BEGSLASH) begin
                  emit.count = 2'd2;
                  emit.bytes = {8'h00, CH_SLASH, CH_LF};
               end else begin
                  emit.count = 2'd1;
                  emit.bytes = {8'h00, 8'h00, CH_SLASH};
               end
            end else begin
               mode_in = (char_code == CH_QUOTE) ? MODE_QUOTES : MODE_TEXT;
               if (mode_ff == MODE_BEGSLASH) begin
                  emit.count = 2'd3;
                  emit.bytes = {char_code, CH_SLASH, CH_LF};
               end else begin
                  emit.count = 2'd2;
                  emit.bytes = {8'h00, char_code, CH_SLASH};
               end
            end
         end
         MODE_NEWLINE: begin
            if (!end_of_input) begin
               if (char_code == CH_SPACE || char_code == CH_TAB ||
                   char_code == CH_LF || char_code == CH_CR) begin
                  mode_in = MODE_NEWLINE;
               end else if (char_code == CH_SLASH) begin
                  mode_in = MODE_BEGSLASH;
               end else begin
                  mode_in    = (char_code == CH_QUOTE) ? MODE_QUOTES : MODE_TEXT;
                  emit.count = 2'd2;
                  emit.bytes = {8'h00, char_code, CH_LF};
               end
            end
         end
         default: begin
            if (end_of_input) begin
               emit.count = 2'd2;
               emit.bytes = {8'h00, CH_LF, CH_SEMI};
            end else if (char_code == CH_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (char_code == CH_LF || char_code == CH_CR) begin
               mode_in = MODE_NEWLINE;
            end else begin
               if (char_code == CH_QUOTE) begin
                  mode_in = MODE_QUOTES;
               end
               prev_in       = char_code;
               emit.count    = 2'd1;
               emit.bytes[0] = char_code;
            end
         end
      endcase
      // End of input starts the next file from the reset state.
      if (end_of_input) begin
         mode_in = MODE_TEXT;
         prev_in = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         prev_ff <= 8'h00;
      end else if (accept) begin
         mode_ff <= mode_in;
         prev_ff <= prev_in;
      end
   end

   assign mode = mode_ff;

endmodule

// File: rtl/jscs_outq.sv
`timescale 1ns / 1ps

module jscs_outq
   import jscs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  emit_type        emit,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last_of_run,
   output outq_status_type status
);

   logic [1:0]                count_ff, count_in;
   logic [MAX_BYTES-1:0][7:0] bytes_ff, bytes_in;
   logic                      take;

   assign rsp_valid       = (count_ff != 2'd0);
   assign rsp_out_char    = bytes_ff[0];
   assign rsp_last_of_run = (count_ff == 2'd1);
   assign take            = rsp_valid && !rsp_stall;

   // A new bundle may enter as the last byte of the current one leaves.
   assign status.free  = !rsp_valid || (take && rsp_last_of_run);
   assign status.count = count_ff;

   always_comb begin
      count_in = count_ff;
      bytes_in = bytes_ff;
      if (load) begin
         count_in = emit.count;
         bytes_in = emit.bytes;
      end else if (take) begin
         count_in = count_ff - 2'd1;
         bytes_in = {8'h00, bytes_ff[2], bytes_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

endmodule
